@@ hw/rtl/segx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segx_pkg
// Shared widths, types and register addresses for the segment intersection
// pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int CoordW   = 24;
  localparam int LimW     = 41;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * CoordW + 2;
  localparam int CrossW   = 2 * CoordW + 3;
  localparam int LoW      = (CrossW + 1) / 2;
  localparam int HiW      = CrossW - LoW;
  localparam int NumW     = DiffW + CrossW;
  localparam int QuoW     = CoordW + 1;
  localparam int CmpW     = (CrossW > LimW) ? CrossW : LimW;
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 3;
  // six front stages, one stage per quotient bit, one output stage
  localparam int NumStages = QuoW + 7;

  localparam logic [CfgAddrW-1:0] AddrLimit = CfgAddrW'(0);
  localparam logic [LimW-1:0]     LimitRst  = LimW'(1);

  typedef logic signed [CoordW-1:0] coord_t;

endpackage
`default_nettype wire

@@ hw/rtl/segx_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segx_in_if
// Input channel: one beat carries the end points of two segments.
// ----------------------------------------------------------------------------
interface segx_in_if;
  logic             valid;
  logic             ready;
  segx_pkg::coord_t a_x;
  segx_pkg::coord_t a_y;
  segx_pkg::coord_t b_x;
  segx_pkg::coord_t b_y;
  segx_pkg::coord_t c_x;
  segx_pkg::coord_t c_y;
  segx_pkg::coord_t d_x;
  segx_pkg::coord_t d_y;

  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/segx_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segx_out_if
// Result channel: hit flag and intersection point.
// ----------------------------------------------------------------------------
interface segx_out_if;
  logic             valid;
  logic             ready;
  logic             hit;
  segx_pkg::coord_t point_x;
  segx_pkg::coord_t point_y;

  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink   (input valid, hit, point_x, point_y, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/segment_intersection.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection
// Fixed-point 2D segment intersection, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while the output is not stalled and returns
// one beat per pair, in order, through six front stages, one restoring divider
// stage per quotient bit, 25 of them, and the output register. Sustained rate
// is one pair per cycle when unstalled. Every stage holds its own valid bit
// and advances whenever it is empty or the stage after it advances, so a
// stalled output only freezes the occupied stages and bubbles are squeezed
// out; the input stays ready while any stage is empty.
// Front stages: differences, six 25x25 products, cross products, parallel and
// range checks, split 25x26 and 25x25 products of |r|*|tn|, and their sum.
// The divider then forms |r|*|tn|/|den| one bit per stage, truncated toward
// zero. parallel_limit lies at byte address 0 of the 64-bit register port;
// change it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module segment_intersection (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  segx_in_if.sink                                in_if,
  segx_out_if.source                             out_if,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [segx_pkg::CfgAddrW-1:0]     paddr,
  input  wire logic [segx_pkg::CfgDataW-1:0]     pwdata,
  output logic      [segx_pkg::CfgDataW-1:0]     prdata,
  output logic                                   pready
);

  localparam int W  = segx_pkg::CoordW;
  localparam int DW = segx_pkg::DiffW;
  localparam int CW = segx_pkg::CrossW;
  localparam int NW = segx_pkg::NumW;
  localparam int QW = segx_pkg::QuoW;
  localparam int NS = segx_pkg::NumStages;
  localparam int LO = segx_pkg::LoW;
  localparam int HI = segx_pkg::HiW;
  localparam int OS = NS - 1;  // output stage

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [segx_pkg::LimW-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= segx_pkg::LimitRst;
    end else if (psel && penable && pwrite && (paddr == segx_pkg::AddrLimit)) begin
      lim_q <= pwdata[segx_pkg::LimW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == segx_pkg::AddrLimit) ? segx_pkg::CfgDataW'(lim_q)
                                                 : '0;

  // --------------------------------------------------------------------------
  // Stage control: a stage advances when it is empty or any later one is
  // empty, or the output beat is taken.
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = out_if.ready || !(&v_q[NS-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= (k == 0) ? in_if.valid : v_q[k-1];
        end
      end
    end
  end

  assign in_if.ready = adv[0];

  // --------------------------------------------------------------------------
  // Stage 1: edge vectors r = B-A, s = D-C, q = C-A
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] rx1_q, ry1_q, sx1_q, sy1_q, qx1_q, qy1_q;
  logic signed [W-1:0]  ax1_q, ay1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rx1_q <= DW'(in_if.b_x) - DW'(in_if.a_x);
      ry1_q <= DW'(in_if.b_y) - DW'(in_if.a_y);
      sx1_q <= DW'(in_if.d_x) - DW'(in_if.c_x);
      sy1_q <= DW'(in_if.d_y) - DW'(in_if.c_y);
      qx1_q <= DW'(in_if.c_x) - DW'(in_if.a_x);
      qy1_q <= DW'(in_if.c_y) - DW'(in_if.a_y);
      ax1_q <= in_if.a_x;
      ay1_q <= in_if.a_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the six products of the three cross products
  // --------------------------------------------------------------------------
  logic signed [segx_pkg::ProdW-1:0] p_rs_q, p_sr_q, p_qs_q, p_sq_q, p_qr_q, p_rq_q;
  logic signed [DW-1:0]              rx2_q, ry2_q;
  logic signed [W-1:0]               ax2_q, ay2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      p_rs_q <= rx1_q * sy1_q;
      p_sr_q <= ry1_q * sx1_q;
      p_qs_q <= qx1_q * sy1_q;
      p_sq_q <= qy1_q * sx1_q;
      p_qr_q <= qx1_q * ry1_q;
      p_rq_q <= qy1_q * rx1_q;
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: den = r x s, tn = q x s, un = q x r
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] den3_q, tn3_q, un3_q;
  logic signed [DW-1:0] rx3_q, ry3_q;
  logic signed [W-1:0]  ax3_q, ay3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      den3_q <= CW'(p_rs_q) - CW'(p_sr_q);
      tn3_q  <= CW'(p_qs_q) - CW'(p_sq_q);
      un3_q  <= CW'(p_qr_q) - CW'(p_rq_q);
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: parallel test, t and u range tests, magnitudes and signs
  // --------------------------------------------------------------------------
  logic          den_neg, tn_neg, un_neg;
  logic [CW-1:0] aden_c, atn_c, aun_c;
  logic [DW-1:0] arx_c, ary_c;
  logic          par_c, t_ok_c, u_ok_c;

  always_comb begin
    den_neg = den3_q[CW-1];
    tn_neg  = tn3_q[CW-1];
    un_neg  = un3_q[CW-1];
    aden_c  = den_neg ? unsigned'(-den3_q) : unsigned'(den3_q);
    atn_c   = tn_neg  ? unsigned'(-tn3_q)  : unsigned'(tn3_q);
    aun_c   = un_neg  ? unsigned'(-un3_q)  : unsigned'(un3_q);
    arx_c   = rx3_q[DW-1] ? unsigned'(-rx3_q) : unsigned'(rx3_q);
    ary_c   = ry3_q[DW-1] ? unsigned'(-ry3_q) : unsigned'(ry3_q);
    // a zero denominator is parallel even with a zero limit
    par_c   = (aden_c == '0) ||
              (segx_pkg::CmpW'(aden_c) < segx_pkg::CmpW'(lim_q));
    // numerator must share the sign of den (or be zero) and not exceed it
    t_ok_c  = !((tn3_q != '0) && (tn_neg != den_neg)) && !(aden_c < atn_c);
    u_ok_c  = !((un3_q != '0) && (un_neg != den_neg)) && !(aden_c < aun_c);
  end

  logic          hit4_q, negx4_q, negy4_q;
  logic [CW-1:0] aden4_q, atn4_q;
  logic [DW-1:0] arx4_q, ary4_q;
  logic signed [W-1:0] ax4_q, ay4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      hit4_q  <= !par_c && t_ok_c && u_ok_c;
      negx4_q <= rx3_q[DW-1] ^ tn_neg ^ den_neg;
      negy4_q <= ry3_q[DW-1] ^ tn_neg ^ den_neg;
      aden4_q <= aden_c;
      atn4_q  <= atn_c;
      arx4_q  <= arx_c;
      ary4_q  <= ary_c;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: |r| * |tn| as two partial products per axis
  // --------------------------------------------------------------------------
  logic [DW+LO-1:0] plx5_q, ply5_q;
  logic [DW+HI-1:0] phx5_q, phy5_q;
  logic             hit5_q, negx5_q, negy5_q;
  logic [CW-1:0]    aden5_q;
  logic signed [W-1:0] ax5_q, ay5_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      plx5_q  <= (DW+LO)'(arx4_q) * (DW+LO)'(atn4_q[LO-1:0]);
      ply5_q  <= (DW+LO)'(ary4_q) * (DW+LO)'(atn4_q[LO-1:0]);
      phx5_q  <= (DW+HI)'(arx4_q) * (DW+HI)'(atn4_q[CW-1:LO]);
      phy5_q  <= (DW+HI)'(ary4_q) * (DW+HI)'(atn4_q[CW-1:LO]);
      hit5_q  <= hit4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      aden5_q <= aden4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6 (divider entry, index 0) and one divider stage per quotient bit
  // --------------------------------------------------------------------------
  logic [NW-1:0]       remx_q [QW+1];
  logic [NW-1:0]       remy_q [QW+1];
  logic [QW-1:0]       quox_q [QW+1];
  logic [QW-1:0]       quoy_q [QW+1];
  logic [CW-1:0]       div_q  [QW+1];
  logic                hitd_q [QW+1];
  logic                negx_q [QW+1];
  logic                negy_q [QW+1];
  logic signed [W-1:0] axd_q  [QW+1];
  logic signed [W-1:0] ayd_q  [QW+1];

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      remx_q[0] <= NW'(plx5_q) + (NW'(phx5_q) << LO);
      remy_q[0] <= NW'(ply5_q) + (NW'(phy5_q) << LO);
      quox_q[0] <= '0;
      quoy_q[0] <= '0;
      div_q[0]  <= aden5_q;
      hitd_q[0] <= hit5_q;
      negx_q[0] <= negx5_q;
      negy_q[0] <= negy5_q;
      axd_q[0]  <= ax5_q;
      ayd_q[0]  <= ay5_q;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int Bit = QW - k;
    logic [NW:0] trx, try_;
    // trial subtract of the divisor aligned to this quotient bit
    assign trx  = (NW+1)'(remx_q[k-1]) - ((NW+1)'(div_q[k-1]) << Bit);
    assign try_ = (NW+1)'(remy_q[k-1]) - ((NW+1)'(div_q[k-1]) << Bit);

    always_ff @(posedge clk_i) begin
      if (adv[5+k]) begin
        remx_q[k] <= trx[NW]  ? remx_q[k-1] : trx[NW-1:0];
        remy_q[k] <= try_[NW] ? remy_q[k-1] : try_[NW-1:0];
        quox_q[k] <= {quox_q[k-1][QW-2:0], !trx[NW]};
        quoy_q[k] <= {quoy_q[k-1][QW-2:0], !try_[NW]};
        div_q[k]  <= div_q[k-1];
        hitd_q[k] <= hitd_q[k-1];
        negx_q[k] <= negx_q[k-1];
        negy_q[k] <= negy_q[k-1];
        axd_q[k]  <= axd_q[k-1];
        ayd_q[k]  <= ayd_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: apply sign, add start point, zero on no hit
  // --------------------------------------------------------------------------
  logic signed [W+1:0] qxs_c, qys_c, sumx_c, sumy_c;

  always_comb begin
    qxs_c  = signed'((W+2)'(quox_q[QW]));
    qys_c  = signed'((W+2)'(quoy_q[QW]));
    sumx_c = (W+2)'(axd_q[QW]) + (negx_q[QW] ? -qxs_c : qxs_c);
    sumy_c = (W+2)'(ayd_q[QW]) + (negy_q[QW] ? -qys_c : qys_c);
  end

  logic                hit_q;
  logic signed [W-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (adv[OS]) begin
      hit_q <= hitd_q[QW];
      px_q  <= hitd_q[QW] ? sumx_c[W-1:0] : '0;
      py_q  <= hitd_q[QW] ? sumy_c[W-1:0] : '0;
    end
  end

  assign out_if.valid   = v_q[OS];
  assign out_if.hit     = hit_q;
  assign out_if.point_x = px_q;
  assign out_if.point_y = py_q;

`ifndef NO_ASSERTIONS
  // an accepted beat always lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> v_q[0])
    else $error("accepted beat lost at pipeline entry");

  // a hit is never flagged on a denominator under the parallel limit
  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && hit4_q |-> (aden4_q != '0) &&
      (segx_pkg::CmpW'(aden4_q) >= segx_pkg::CmpW'(lim_q)))
    else $error("hit with near-parallel segments");

  // after the last divider stage the remainders are below the divisor
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5+QW] && hitd_q[QW] |-> (remx_q[QW] < NW'(div_q[QW])) &&
      (remy_q[QW] < NW'(div_q[QW])))
    else $error("divider remainder out of range");

  // a miss carries a zero point
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.hit |-> (out_if.point_x == '0) && (out_if.point_y == '0))
    else $error("miss with nonzero point");
`endif

endmodule
`default_nettype wire
